// ----- design/rbb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the RGB box blur block: widths, codes, defaults and shared types.
// No dependencies; every other design file but rbb_ram refers to it by scoped names.
package rbb_pkg;

  // Field widths fixed by the interface
  localparam int unsigned PIX_W   = 8;   // one colour channel
  localparam int unsigned COORD_W = 8;   // column / row fields
  localparam int unsigned CFG_W   = 9;   // widest configuration register
  localparam int unsigned CIDX_W  = 2;   // configuration register index
  localparam int unsigned RAD_W   = 4;   // blur_radius register
  // Internal coordinate width, enough for sizes up to 2048
  localparam int unsigned CRD_W   = 12;

  // Parameter defaults
  localparam int unsigned MAX_COLUMNS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF    = 256;
  localparam int unsigned MAX_RADIUS_DEF  = 15;

  // Register reset values
  localparam int unsigned IMAGE_WIDTH_RST  = 256;
  localparam int unsigned IMAGE_HEIGHT_RST = 256;
  localparam int unsigned BLUR_RADIUS_RST  = 10;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Top-level control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_t;

  // Window geometry settings handed to the scanner
  typedef struct packed {
    logic [CRD_W-1:0] w_last;   // last column in use
    logic [CRD_W-1:0] h_last;   // last row in use
    logic [RAD_W-1:0] rad;      // saturated radius
  } win_cfg_t;

endpackage

// ----- design/rbb_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the RGB box blur block: valid/ready and one item's fields.
// Depends on rbb_pkg for field widths.
interface rbb_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [rbb_pkg::COORD_W-1:0] column;
  logic [rbb_pkg::COORD_W-1:0] row;
  logic [rbb_pkg::PIX_W-1:0]   red_in;
  logic [rbb_pkg::PIX_W-1:0]   green_in;
  logic [rbb_pkg::PIX_W-1:0]   blue_in;

  modport source (output valid, operation, column, row, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, operation, column, row, red_in, green_in, blue_in,
                  output ready);
endinterface

// ----- design/rbb_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the RGB box blur block: valid/ready and the blurred pixel.
// Depends on rbb_pkg for field widths.
interface rbb_out_if;
  logic                     valid;
  logic                     ready;
  logic [rbb_pkg::PIX_W-1:0] red_out;
  logic [rbb_pkg::PIX_W-1:0] green_out;
  logic [rbb_pkg::PIX_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ----- design/rbb_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rbb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/rbb_scan.sv -----
`timescale 1ns / 1ps
// Window scanner: clips the window, walks it one pixel a cycle through the frame
// store read port and accumulates per-channel sums and the pixel count. Uses rbb_pkg.
module rbb_scan #(
  parameter int unsigned COL_AW = 8,
  parameter int unsigned ROW_AW = 8,
  parameter int unsigned SUM_W  = 17,
  parameter int unsigned CNT_W  = 10,
  localparam int unsigned AW    = ROW_AW + COL_AW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rbb_pkg::COORD_W-1:0] col,
  input  logic [rbb_pkg::COORD_W-1:0] row,
  input  rbb_pkg::win_cfg_t           cfg,
  // frame store read port
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [3*rbb_pkg::PIX_W-1:0] rd_data,
  // results
  output logic                        done,
  output logic [SUM_W-1:0]            sum_red,
  output logic [SUM_W-1:0]            sum_green,
  output logic [SUM_W-1:0]            sum_blue,
  output logic [CNT_W-1:0]            count
);

  localparam int unsigned CW = rbb_pkg::CRD_W;
  localparam int unsigned PW = rbb_pkg::PIX_W;

  logic [CW-1:0] rad_x, cx, cy, x0, x1, y0, y1, cx_hi, cy_hi;
  logic [CW-1:0] x_r, y_r, x0_r, x1_r, y1_r;
  logic          issue_r, rd_vld_r, rd_last_r, done_r;
  logic          last_pix;
  logic [SUM_W-1:0] sr_r, sg_r, sb_r;
  logic [CNT_W-1:0] cnt_r;

  // Clip the window to the image at start
  always_comb begin
    rad_x = CW'(cfg.rad);
    cx    = (CW'(col) > cfg.w_last) ? cfg.w_last : CW'(col);
    cy    = (CW'(row) > cfg.h_last) ? cfg.h_last : CW'(row);
    x0    = (cx > rad_x) ? cx - rad_x : '0;
    y0    = (cy > rad_x) ? cy - rad_x : '0;
    cx_hi = cx + rad_x;
    cy_hi = cy + rad_x;
    x1    = (cx_hi > cfg.w_last) ? cfg.w_last : cx_hi;
    y1    = (cy_hi > cfg.h_last) ? cfg.h_last : cy_hi;
  end

  assign last_pix = (x_r == x1_r) && (y_r == y1_r);

  // Address walk, raster order over the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r   <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      rd_vld_r  <= issue_r;
      rd_last_r <= issue_r & last_pix;
      done_r    <= rd_vld_r & rd_last_r;
      if (start) begin
        issue_r <= 1'b1;
      end else if (issue_r && last_pix) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r  <= x0;
      y_r  <= y0;
      x0_r <= x0;
      x1_r <= x1;
      y1_r <= y1;
    end else if (issue_r) begin
      if (x_r == x1_r) begin
        x_r <= x0_r;
        y_r <= y_r + CW'(1);
      end else begin
        x_r <= x_r + CW'(1);
      end
    end
  end

  assign rd_en   = issue_r;
  assign rd_addr = {y_r[ROW_AW-1:0], x_r[COL_AW-1:0]};

  // Accumulate returned pixels
  always_ff @(posedge clk) begin
    if (start) begin
      sr_r  <= '0;
      sg_r  <= '0;
      sb_r  <= '0;
      cnt_r <= '0;
    end else if (rd_vld_r) begin
      sr_r  <= sr_r + SUM_W'(rd_data[3*PW-1:2*PW]);
      sg_r  <= sg_r + SUM_W'(rd_data[2*PW-1:PW]);
      sb_r  <= sb_r + SUM_W'(rd_data[PW-1:0]);
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign done      = done_r;
  assign sum_red   = sr_r;
  assign sum_green = sg_r;
  assign sum_blue  = sb_r;
  assign count     = cnt_r;

endmodule

// ----- design/rbb_div.sv -----
`timescale 1ns / 1ps
// Three-lane restoring divider, one quotient bit per cycle for each channel,
// sharing one shifted divisor. Uses rbb_pkg for the pixel width.
module rbb_div #(
  parameter int unsigned SUM_W = 17,
  parameter int unsigned CNT_W = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [SUM_W-1:0]          sum_red,
  input  logic [SUM_W-1:0]          sum_green,
  input  logic [SUM_W-1:0]          sum_blue,
  input  logic [CNT_W-1:0]          count,
  output logic                      done,
  output logic [rbb_pkg::PIX_W-1:0] q_red,
  output logic [rbb_pkg::PIX_W-1:0] q_green,
  output logic [rbb_pkg::PIX_W-1:0] q_blue
);

  localparam int unsigned PW     = rbb_pkg::PIX_W;
  localparam int unsigned DV_W   = SUM_W + PW;
  localparam int unsigned STEP_W = $clog2(PW);

  logic              busy_r, done_r;
  logic [STEP_W-1:0] step_r;
  logic [DV_W-1:0]   dvs_r;
  logic [SUM_W-1:0]  rem_r [3];
  logic [PW-1:0]     q_r   [3];

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(PW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: compare-subtract per lane, divisor shifts right
  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r    <= DV_W'(count) << (PW - 1);
      rem_r[0] <= sum_red;
      rem_r[1] <= sum_green;
      rem_r[2] <= sum_blue;
      for (int i = 0; i < 3; i++) begin
        q_r[i] <= '0;
      end
    end else if (busy_r) begin
      dvs_r <= dvs_r >> 1;
      for (int i = 0; i < 3; i++) begin
        if (DV_W'(rem_r[i]) >= dvs_r) begin
          rem_r[i] <= rem_r[i] - dvs_r[SUM_W-1:0];
          q_r[i]   <= {q_r[i][PW-2:0], 1'b1};
        end else begin
          q_r[i]   <= {q_r[i][PW-2:0], 1'b0};
        end
      end
    end
  end

  assign done    = done_r;
  assign q_red   = q_r[0];
  assign q_green = q_r[1];
  assign q_blue  = q_r[2];

endmodule

// ----- design/rgb_box_blur_clamped_window.sv -----
`timescale 1ns / 1ps
// RGB box blur over a stored frame, window clipped to the image bounds.
// Write beat: stored if in range, no result. Query beat: the clipped window's N pixels (up to
// (2R+1)^2, 441 at radius 10) are read one by one through the single read port of the frame
// store, then a divider forms the mean. One item at a time.
// Reset (rst_n low, synchronous) clears control and sets 256 x 256, radius 10, saturated
// to the parameters; the frame store is not cleared.
module rgb_box_blur_clamped_window #(
  parameter int unsigned MAX_COLUMNS = rbb_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = rbb_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_RADIUS  = rbb_pkg::MAX_RADIUS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rbb_in_if.sink                     in_ch,
  rbb_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [rbb_pkg::CIDX_W-1:0] cfg_index,
  input  logic [rbb_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int unsigned PW      = rbb_pkg::PIX_W;
  localparam int unsigned CW      = rbb_pkg::CRD_W;
  localparam int unsigned RW      = rbb_pkg::RAD_W;
  localparam int unsigned COL_AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned AW      = ROW_AW + COL_AW;
  localparam int unsigned DEPTH   = 2 ** AW;
  localparam int unsigned WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int unsigned CNT_W   = $clog2(WIN_MAX + 1);
  localparam int unsigned SUM_W   = $clog2(WIN_MAX * ((2 ** PW) - 1) + 1);
  localparam int unsigned W_RST   = (rbb_pkg::IMAGE_WIDTH_RST > MAX_COLUMNS) ?
                                    MAX_COLUMNS : rbb_pkg::IMAGE_WIDTH_RST;
  localparam int unsigned H_RST   = (rbb_pkg::IMAGE_HEIGHT_RST > MAX_ROWS) ?
                                    MAX_ROWS : rbb_pkg::IMAGE_HEIGHT_RST;
  localparam int unsigned R_RST   = (rbb_pkg::BLUR_RADIUS_RST > MAX_RADIUS) ?
                                    MAX_RADIUS : rbb_pkg::BLUR_RADIUS_RST;

  rbb_pkg::state_t   state_r, state_nxt;
  rbb_pkg::win_cfg_t win_cfg_r;

  logic              in_fire, out_fire, is_query, wr_en, wr_in_range;
  logic              scan_start, div_start, out_load;
  logic              rd_en, scan_done, div_done;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CW-1:0]     wr_row_ext, wr_col_ext;
  logic [3*PW-1:0]   rd_data;
  logic [SUM_W-1:0]  sum_red, sum_green, sum_blue;
  logic [CNT_W-1:0]  count;
  logic [PW-1:0]     q_red, q_green, q_blue;
  logic              out_valid_r;
  logic [PW-1:0]     out_red_r, out_green_r, out_blue_r;
  logic [CW-1:0]     cfg_ext;

  // Saturate a size register to 1..max and return the last index in use
  function automatic logic [CW-1:0] size_last(input logic [CW-1:0] v,
                                              input logic [CW-1:0] maxv);
    logic [CW-1:0] s;
    s = (v == '0) ? CW'(1) : ((v > maxv) ? maxv : v);
    return s - CW'(1);
  endfunction

  // Configuration registers, held in their saturated form
  assign cfg_ext = CW'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r.w_last <= CW'(W_RST - 1);
      win_cfg_r.h_last <= CW'(H_RST - 1);
      win_cfg_r.rad    <= RW'(R_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        rbb_pkg::REG_IMAGE_WIDTH:  win_cfg_r.w_last <= size_last(cfg_ext, CW'(MAX_COLUMNS));
        rbb_pkg::REG_IMAGE_HEIGHT: win_cfg_r.h_last <= size_last(cfg_ext, CW'(MAX_ROWS));
        rbb_pkg::REG_BLUR_RADIUS: begin
          win_cfg_r.rad <= (CW'(cfg_wdata[RW-1:0]) > CW'(MAX_RADIUS)) ?
                           RW'(MAX_RADIUS) : cfg_wdata[RW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_ch.ready = (state_r == rbb_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign out_fire    = out_valid_r & out_ch.ready;
  assign is_query    = (in_ch.operation == rbb_pkg::OP_QUERY);

  // Pixel writes outside the store are dropped
  assign wr_in_range = (32'(in_ch.column) < 32'(MAX_COLUMNS)) &&
                       (32'(in_ch.row) < 32'(MAX_ROWS));
  assign wr_en       = in_fire && (in_ch.operation == rbb_pkg::OP_WRITE) && wr_in_range;
  assign wr_row_ext  = CW'(in_ch.row);
  assign wr_col_ext  = CW'(in_ch.column);
  assign wr_addr     = {wr_row_ext[ROW_AW-1:0], wr_col_ext[COL_AW-1:0]};

  // Control sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    scan_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      rbb_pkg::ST_IDLE: begin
        if (in_fire && is_query) begin
          scan_start = 1'b1;
          state_nxt  = rbb_pkg::ST_SCAN;
        end
      end
      rbb_pkg::ST_SCAN: begin
        if (scan_done) begin
          div_start = 1'b1;
          state_nxt = rbb_pkg::ST_DIV;
        end
      end
      rbb_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = rbb_pkg::ST_OUT;
        end
      end
      rbb_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = rbb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rbb_pkg::ST_IDLE;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red_r   <= q_red;
      out_green_r <= q_green;
      out_blue_r  <= q_blue;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_red_r;
  assign out_ch.green_out = out_green_r;
  assign out_ch.blue_out  = out_blue_r;

  // Frame store
  rbb_ram #(
    .WIDTH (3 * PW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_ch.red_in, in_ch.green_in, in_ch.blue_in}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Window walk and accumulation
  rbb_scan #(
    .COL_AW (COL_AW),
    .ROW_AW (ROW_AW),
    .SUM_W  (SUM_W),
    .CNT_W  (CNT_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .col       (in_ch.column),
    .row       (in_ch.row),
    .cfg       (win_cfg_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .done      (scan_done),
    .sum_red   (sum_red),
    .sum_green (sum_green),
    .sum_blue  (sum_blue),
    .count     (count)
  );

  // Mean by pixel count
  rbb_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .sum_red   (sum_red),
    .sum_green (sum_green),
    .sum_blue  (sum_blue),
    .count     (count),
    .done      (div_done),
    .q_red     (q_red),
    .q_green   (q_green),
    .q_blue    (q_blue)
  );

endmodule

// ----- bench/rbb_blur_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the RGB box blur block: mirrors the frame store and geometry
// registers, predicts each blurred pixel and compares it. Needs rbb_pkg and both channel interfaces.
module rbb_blur_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  rbb_in_if                          in_ch,
  rbb_out_if                         out_ch,
  input  logic                       cfg_we,
  input  logic [rbb_pkg::CIDX_W-1:0] cfg_index,
  input  logic [rbb_pkg::CFG_W-1:0]  cfg_wdata,
  output int unsigned                blur_failures,
  output int unsigned                blurs_outstanding,
  output int unsigned                blurs_compared
);
  import rbb_pkg::*;

  localparam int unsigned STORE_DEPTH  = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // Shadow of the frame store and of the geometry registers
  rgb_t             frame_copy [STORE_DEPTH];
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic [RAD_W-1:0] radius_q;

  // Blurred pixels owed by the block, oldest first
  rgb_t             blur_q [$];
  int unsigned      fail_cnt;
  int unsigned      compared_cnt;

  // Per-channel mean over the clipped square window around a (clamped) centre
  function automatic rgb_t window_mean(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] row);
    int unsigned w, h, rad, cx, cy, x_lo, x_hi, y_lo, y_hi, x, y;
    int unsigned sum_r, sum_g, sum_b, area;
    rgb_t        px;
    rgb_t        mean;
    w   = (width_q == 0) ? 1 : ((width_q > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : width_q);
    h   = (height_q == 0) ? 1 : ((height_q > MAX_ROWS_DEF) ? MAX_ROWS_DEF : height_q);
    rad = (radius_q > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_q;
    cx  = (col > w - 1) ? w - 1 : col;
    cy  = (row > h - 1) ? h - 1 : row;
    x_lo = (cx > rad) ? cx - rad : 0;
    y_lo = (cy > rad) ? cy - rad : 0;
    x_hi = (cx + rad > w - 1) ? w - 1 : cx + rad;
    y_hi = (cy + rad > h - 1) ? h - 1 : cy + rad;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (y = y_lo; y <= y_hi; y++) begin
      for (x = x_lo; x <= x_hi; x++) begin
        px = frame_copy[y * MAX_COLUMNS_DEF + x];
        sum_r += px.red;
        sum_g += px.green;
        sum_b += px.blue;
      end
    end
    area = (x_hi - x_lo + 1) * (y_hi - y_lo + 1);
    // truncating division
    mean.red   = PIX_W'(sum_r / area);
    mean.green = PIX_W'(sum_g / area);
    mean.blue  = PIX_W'(sum_b / area);
    return mean;
  endfunction

  always @(posedge clk) begin : watch_beats
    rgb_t got;
    rgb_t want;
    if (!rst_n) begin
      width_q  = IMAGE_WIDTH_RST;
      height_q = IMAGE_HEIGHT_RST;
      radius_q = BLUR_RADIUS_RST;
      blur_q.delete();
    end else begin
      // register writes; unknown indexes fall through
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_q  = cfg_wdata;
          REG_IMAGE_HEIGHT: height_q = cfg_wdata;
          REG_BLUR_RADIUS:  radius_q = cfg_wdata[RAD_W-1:0];
          default: ;
        endcase
      end

      // input beat: store a pixel or queue the blurred value it will produce
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_WRITE)
          frame_copy[in_ch.row * MAX_COLUMNS_DEF + in_ch.column] =
            {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
        else
          blur_q.push_back(window_mean(in_ch.column, in_ch.row));
      end

      // result beat against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.red_out, out_ch.green_out, out_ch.blue_out};
        if (blur_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("%0t: blurred pixel r=%0d g=%0d b=%0d with nothing outstanding",
                     $time, got.red, got.green, got.blue);
        end else begin
          want = blur_q.pop_front();
          compared_cnt++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
              $display("%0t: blur mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $time, want.red, want.green, want.blue, got.red, got.green, got.blue);
          end
        end
      end
    end
    blur_failures     <= fail_cnt;
    blurs_outstanding <= blur_q.size();
    blurs_compared    <= compared_cnt;
  end

endmodule

// ----- bench/tb_rgb_box_blur_clamped_window.sv -----
`timescale 1ns / 1ps
// Top of the RGB box blur testbench: clock, reset, pixel/query stimulus and verdict.
// Needs rbb_pkg, rbb_in_if, rbb_out_if, the blur block and rbb_blur_checker.
module tb_rgb_box_blur_clamped_window;
  import rbb_pkg::*;

  localparam int unsigned ITEMS_TARGET  = 1330;
  localparam int unsigned IDLE_LIMIT    = 10000;  // well above the slowest query plus stalls
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  rbb_in_if  in_ch ();
  rbb_out_if out_ch ();

  int unsigned blur_failures;
  int unsigned blurs_outstanding;
  int unsigned blurs_compared;

  // Geometry as the block sees it, for keeping every window fully written
  int unsigned img_w, img_h, img_r;
  int unsigned focus_x, focus_y;
  bit          pix_written [0:MAX_COLUMNS_DEF*MAX_ROWS_DEF-1];

  bit          tx_steady;
  int unsigned tx_burst_left;
  bit          rx_busy;
  int unsigned rx_hold;
  int unsigned idle_cycles;

  int unsigned n_writes, n_fills, n_queries, n_settings, stim_items;

  rgb_box_blur_clamped_window i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rbb_blur_checker i_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .blur_failures     (blur_failures),
    .blurs_outstanding (blurs_outstanding),
    .blurs_compared    (blurs_compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stretches of ready and stall of random length while busy
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_busy) begin
      out_ch.ready <= ($urandom_range(0, 2) != 0);
      rx_hold      <= $urandom_range(0, 30);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d blurred pixels outstanding",
               IDLE_LIMIT, blurs_outstanding);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Channel level, biased towards black and full scale
  function automatic logic [PIX_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] near_focus(input int unsigned base);
    return COORD_W'(base + $urandom_range(0, 7));
  endfunction

  // One input beat, with burst/gap pacing unless the sender runs steady
  task automatic send_beat(input logic op, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [PIX_W-1:0] r,
                           input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 16);
      if (!tx_steady) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.column    <= col;
    in_ch.row       <= row;
    in_ch.red_in    <= r;
    in_ch.green_in  <= g;
    in_ch.blue_in   <= b;
    do @(posedge clk); while (!in_ch.ready);
    tx_burst_left--;
    stim_items++;
    if (op == OP_WRITE) begin
      pix_written[{row, col}] = 1'b1;
      n_writes++;
    end else begin
      n_queries++;
    end
  endtask

  // Query, first writing any pixel of its window that has never been stored
  task automatic query_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int unsigned cx, cy, x, y, x_lo, x_hi, y_lo, y_hi;
    cx   = (col > img_w - 1) ? img_w - 1 : col;
    cy   = (row > img_h - 1) ? img_h - 1 : row;
    x_lo = (cx > img_r) ? cx - img_r : 0;
    y_lo = (cy > img_r) ? cy - img_r : 0;
    x_hi = (cx + img_r > img_w - 1) ? img_w - 1 : cx + img_r;
    y_hi = (cy + img_r > img_h - 1) ? img_h - 1 : cy + img_r;
    for (y = y_lo; y <= y_hi; y++) begin
      for (x = x_lo; x <= x_hi; x++) begin
        if (!pix_written[y * MAX_COLUMNS_DEF + x]) begin
          send_beat(OP_WRITE, COORD_W'(x), COORD_W'(y), rand_level(), rand_level(),
                    rand_level());
          n_fills++;
        end
      end
    end
    send_beat(OP_QUERY, col, row, rand_level(), rand_level(), rand_level());
  endtask

  // Hold the sender until every blurred pixel owed has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (blurs_outstanding != 0);
  endtask

  task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // New geometry, only once the block has gone quiet
  task automatic set_geometry(input logic [CFG_W-1:0] w_word, input logic [CFG_W-1:0] h_word,
                              input logic [RAD_W-1:0] rad);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if ($urandom_range(0, 3) == 0)
      write_register(REG_UNUSED, CFG_W'($urandom));
    write_register(REG_IMAGE_WIDTH, w_word);
    write_register(REG_IMAGE_HEIGHT, h_word);
    // spare upper bits of the radius word carry noise
    write_register(REG_BLUR_RADIUS, {(CFG_W-RAD_W)'($urandom), rad});
    cfg_we <= 1'b0;
    img_w = (w_word == 0) ? 1 : ((w_word > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : w_word);
    img_h = (h_word == 0) ? 1 : ((h_word > MAX_ROWS_DEF) ? MAX_ROWS_DEF : h_word);
    img_r = (rad > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : rad;
    n_settings++;
  endtask

  // Random beat: mostly queries, the rest overwrites near the query area or anywhere
  task automatic random_beat();
    logic [COORD_W-1:0] col, row;
    bit                 img_compact;
    img_compact = (img_w <= 16) && (img_h <= 16);
    if ($urandom_range(0, 9) < 6) begin
      if (img_compact) begin
        // anywhere in the store range, so clamping gets plenty of use
        col = COORD_W'($urandom);
        row = COORD_W'($urandom);
      end else begin
        col = near_focus(focus_x);
        row = near_focus(focus_y);
      end
      query_pixel(col, row);
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        col = COORD_W'($urandom);
        row = COORD_W'($urandom);
      end else if (img_compact) begin
        col = COORD_W'($urandom_range(0, img_w - 1));
        row = COORD_W'($urandom_range(0, img_h - 1));
      end else begin
        col = near_focus(focus_x);
        row = near_focus(focus_y);
      end
      send_beat(OP_WRITE, col, row, rand_level(), rand_level(), rand_level());
    end
  endtask

  initial begin : stimulus
    int unsigned      phase_no, phase_len, pause_at, k, pick;
    logic [CFG_W-1:0] w_word, h_word;
    logic [RAD_W-1:0] rad;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.column    = '0;
    in_ch.row       = '0;
    in_ch.red_in    = '0;
    in_ch.green_in  = '0;
    in_ch.blue_in   = '0;
    out_ch.ready    = 1'b0;
    tx_steady       = 1'b1;
    img_w           = IMAGE_WIDTH_RST;
    img_h           = IMAGE_HEIGHT_RST;
    img_r           = BLUR_RADIUS_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused register index, tiny image, corners and clamped queries
    write_register(REG_UNUSED, '1);
    cfg_we <= 1'b0;
    set_geometry(9'd4, 9'd3, 4'd1);
    send_beat(OP_WRITE, 8'd0, 8'd0, '1, '1, '1);
    send_beat(OP_WRITE, 8'd255, 8'd255, '0, '0, '0);
    send_beat(OP_WRITE, 8'd3, 8'd2, '0, '1, '0);
    send_beat(OP_WRITE, 8'd255, 8'd0, '0, '0, '1);
    query_pixel(8'd0, 8'd0);
    query_pixel(8'd255, 8'd255);
    query_pixel(8'd2, 8'd1);
    query_pixel(8'd3, 8'd0);
    // zero width acts as one column, oversize height saturates, radius zero
    set_geometry(9'd0, 9'd511, 4'd0);
    query_pixel(8'd200, 8'd255);
    query_pixel(8'd0, 8'd0);
    // full width, single row, widest radius
    set_geometry(9'd511, 9'd0, 4'd15);
    query_pixel(8'd255, 8'd128);
    query_pixel(8'd0, 8'd0);

    // Random phases, each under its own geometry and pacing
    phase_no = 0;
    while (stim_items < ITEMS_TARGET) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: begin
          w_word = CFG_W'($urandom_range(1, 16));
          h_word = CFG_W'($urandom_range(1, 16));
        end
        1: begin
          w_word = 9'd256;
          h_word = 9'd256;
        end
        2: begin
          w_word = 9'd1;
          h_word = 9'd1;
        end
        3: begin
          w_word = CFG_W'($urandom_range(257, 511));
          h_word = 9'd0;
        end
        4: begin
          w_word = 9'd256;
          h_word = CFG_W'($urandom_range(1, 8));
        end
        5: begin
          w_word = CFG_W'($urandom_range(1, 8));
          h_word = 9'd256;
        end
        6: begin
          w_word = CFG_W'($urandom_range(0, 511));
          h_word = CFG_W'($urandom_range(0, 511));
        end
        default: begin
          // reset geometry
          w_word = CFG_W'(IMAGE_WIDTH_RST);
          h_word = CFG_W'(IMAGE_HEIGHT_RST);
        end
      endcase
      if (pick == 7)
        rad = RAD_W'(BLUR_RADIUS_RST);
      else if ($urandom_range(0, 3) == 0)
        rad = ($urandom_range(0, 1) == 0) ? '0 : RAD_W'(MAX_RADIUS_DEF);
      else
        rad = RAD_W'($urandom_range(0, MAX_RADIUS_DEF));
      set_geometry(w_word, h_word, rad);

      // large images stay anchored at the origin, so written areas get reused
      // and the fill writes stay a small share of the beats
      focus_x   = 0;
      focus_y   = 0;
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_busy  <= ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 120);
      pause_at  = $urandom_range(0, phase_len - 1);
      for (k = 0; k < phase_len && stim_items < ITEMS_TARGET; k++) begin
        if (k == pause_at && phase_no % 2 == 0)
          drain_results();
        random_beat();
      end
      phase_no++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d pixel writes (%0d to complete query windows), %0d blur queries",
             n_writes, n_fills, n_queries);
    $display("over %0d geometry settings; %0d blurred pixels compared, %0d failures",
             n_settings, blurs_compared, blur_failures);
    if (blur_failures == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
